### design/ikcd_pkg.sv
// shared types, constants and helper functions of the ccd inverse kinematics block
`timescale 1ns / 1ps
package ikcd_pkg;

    localparam int NUM_JOINTS   = 16;
    localparam int JW           = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int CORDIC_STEPS = 16;
    localparam int CIW          = $clog2(CORDIC_STEPS);

    localparam int CXW = 46;   // cordic x / y datapath
    localparam int CZW = 34;   // cordic angle accumulator, 2^32 per turn
    localparam int DW  = 44;   // dot and cross products
    localparam int MAW = 25;   // shared multiplier operand a
    localparam int MBW = 22;   // shared multiplier operand b
    localparam int MPW = MAW + MBW;

    localparam int SQW   = 42; // sum of squares
    localparam int ROOTW = 21; // integer square root
    localparam int RCW   = $clog2(ROOTW);

    localparam int GAIN_Q16      = 39797;
    localparam int VEL_GAIN_Q16  = 655;
    localparam int VEL_DECAY_Q16 = 58982;
    localparam int MAX_UPDATES   = 48;
    localparam int DIST_MAX      = 1048575;
    localparam int VEL_MAX       = 8388607;
    localparam int VEL_MIN       = -8388608;

    localparam logic signed [19:0] BASE_X_RST      = 20'sd102400;
    localparam logic signed [19:0] BASE_Y_RST      = 20'sd102400;
    localparam logic [15:0]        START_ANGLE_RST = 16'd49152;
    localparam logic [15:0]        LINK_LENGTH_RST = 16'd4096;
    localparam logic [13:0]        JOINT_LIMIT_RST = 14'd1043;
    localparam logic [13:0]        STEP_LIMIT_RST  = 14'd1043;

    typedef enum logic [2:0] {
        REG_BASE_X      = 3'd0,
        REG_BASE_Y      = 3'd1,
        REG_START_ANGLE = 3'd2,
        REG_LINK_LENGTH = 3'd3,
        REG_JOINT_LIMIT = 3'd4,
        REG_STEP_LIMIT  = 3'd5
    } reg_index_t;

    typedef enum logic [0:0] {
        CORDIC_ROTATE = 1'b0,
        CORDIC_VECTOR = 1'b1
    } cordic_mode_t;

    typedef struct packed {
        logic         start;
        cordic_mode_t mode;
    } cordic_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F_MUL,
        ST_F_ROT,
        ST_F_WAIT,
        ST_D_MUL,
        ST_D_VEC,
        ST_D_WAIT,
        ST_G_MUL,
        ST_G_ADD,
        ST_J_ANG,
        ST_J_VEL,
        ST_S_MUL,
        ST_S_ROOT,
        ST_S_WAIT,
        ST_DONE
    } state_t;

    // atan(2^-i), 2^32 units per turn
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
        logic signed [19:0] r;
        if (v > 22'sd524287) begin
            r = 20'sd524287;
        end else if (v < -22'sd524288) begin
            r = -20'sd524288;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage

### design/ccd_inverse_kinematics_step.sv
// top level: damped ccd inverse kinematics step with sequencer, shared multiplier and cordic
`timescale 1ns / 1ps
// usage
// - input channel (in_valid / in_ready) carries one target point per transfer;
//   the output channel (out_valid / out_ready) returns one result per target:
//   the new chain tip, its distance to the target and the next active joint
// - registers sit on the apb port at byte address 4*index; writes are taken
//   at any time but are meant for idle periods; point positions built from
//   base, start angle and link length change only when the next step runs
// - the length of a step is set by the single cordic unit, which rebuilds
//   the chain twice per step (once with the geometry of the last step to
//   find the active joint and the tip, once after the joint update) plus
//   the angle measurement, and by the bit-serial square root
// - in_ready is high only in the idle state, so one target is in flight at a
//   time; the next target is taken the cycle after a result is loaded
// - the result sits in an output register; if the receiver stalls, a
//   following step runs to completion and then waits until that register
//   is free
// - reset clears all joint angles and velocities, restores register defaults
//   and the straight chain; no clearing pass is needed
module ccd_inverse_kinematics_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [19:0] target_x,
    input  logic signed [19:0] target_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [19:0] tip_x,
    output logic signed [19:0] tip_y,
    output logic [19:0]        tip_distance,
    output logic [3:0]         active_joint
);
    import ikcd_pkg::*;

    localparam logic signed [CZW-1:0] Z_QTR  = CZW'(64'sd1073741824);
    localparam logic signed [CZW-1:0] Z_HALF = CZW'(64'sd2147483648);

    // configuration registers
    logic signed [19:0] base_x_reg, base_y_reg;
    logic [15:0]        start_reg, len_reg;
    logic [13:0]        jlim_reg, slim_reg;
    // geometry used by the last forward pass
    logic signed [19:0] snap_bx_reg, snap_by_reg, snap_bx_next, snap_by_next;
    logic [15:0]        snap_start_reg, snap_len_reg, snap_start_next, snap_len_next;

    state_t state_reg, state_next;

    // joint state
    logic signed [15:0] ang_mem_reg [NUM_JOINTS];
    logic signed [23:0] vel_mem_reg [NUM_JOINTS];
    logic               ang_we, vel_we;
    logic [JW-1:0]      vel_widx;
    logic signed [15:0] ang_wdata;
    logic signed [23:0] vel_wdata;

    // control
    logic [JW-1:0]      jcnt_reg, jcnt_next, act_reg, act_next, rd_idx;
    logic [2:0]         mstep_reg, mstep_next;
    logic               post_reg, post_next;
    logic [5:0]         upd_reg, upd_next;
    logic [19:0]        last_reg, last_next;
    logic               out_valid_reg, out_valid_next;

    // datapath
    logic signed [19:0] gx_reg, gx_next, gy_reg, gy_next;
    logic signed [19:0] px_reg, px_next, py_reg, py_next;
    logic signed [19:0] jx_reg, jx_next, jy_reg, jy_next;
    logic [15:0]        ang_reg, ang_next;
    logic               flip_reg, flip_next;
    logic signed [20:0] tx_reg, tx_next, ty_reg, ty_next;
    logic signed [20:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [DW-1:0] dot_reg, dot_next, cross_reg, cross_next;
    logic signed [15:0] err_reg, err_next;
    logic [SQW-1:0]     sq_reg, sq_next;
    logic [19:0]        dist_reg, dist_next;
    logic signed [19:0] tip_x_reg, tip_x_next, tip_y_reg, tip_y_next;
    logic [19:0]        tdist_reg, tdist_next;
    logic [3:0]         tact_reg, tact_next;

    // shared multiplier
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [MPW-1:0] prod_reg;

    // cordic and square root
    cordic_req_t           cor_req;
    logic signed [CXW-1:0] cor_x0, cor_y0, cor_x, cor_y;
    logic signed [CZW-1:0] cor_z0, cor_z;
    logic                  cor_done;
    logic                  sq_start, sq_done;
    logic [ROOTW-1:0]      root;

    // derived values
    logic signed [15:0] ang_rd;
    logic signed [23:0] vel_rd;
    logic               last_j, in_fire, out_free, cfg_we;
    logic signed [CZW-1:0] rot_z, rot_z0;
    logic               rot_flip;
    logic signed [CXW-1:0] rc_wide, rs_wide;
    logic signed [18:0] rc, rs, rc_f, rs_f;
    logic signed [19:0] px_new, py_new;
    logic               vec_neg, vec_zero;
    logic signed [CXW-1:0] dot_x, cross_x, vec_x0, vec_y0;
    logic signed [CZW-1:0] vz_round;
    logic signed [15:0] vang;
    logic signed [16:0] vang17, slim17, err17;
    logic signed [MPW-1:0] g_round, d_round;
    logic signed [17:0] g18;
    logic signed [25:0] vsum;
    logic signed [23:0] vsat;
    logic signed [24:0] vr_wide;
    logic signed [16:0] vr;
    logic signed [17:0] asum, jl18;
    logic signed [15:0] aclamp, jl16;
    logic [19:0]        dist_sat;
    logic               hit, grew, move_on;
    logic [JW:0]        jcnt_inc;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    // apb register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            base_x_reg <= BASE_X_RST;
            base_y_reg <= BASE_Y_RST;
            start_reg  <= START_ANGLE_RST;
            len_reg    <= LINK_LENGTH_RST;
            jlim_reg   <= JOINT_LIMIT_RST;
            slim_reg   <= STEP_LIMIT_RST;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_BASE_X:      base_x_reg <= pwdata[19:0];
                REG_BASE_Y:      base_y_reg <= pwdata[19:0];
                REG_START_ANGLE: start_reg  <= pwdata[15:0];
                REG_LINK_LENGTH: len_reg    <= pwdata[15:0];
                REG_JOINT_LIMIT: jlim_reg   <= pwdata[13:0];
                REG_STEP_LIMIT:  slim_reg   <= pwdata[13:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_BASE_X:      prdata = 32'(base_x_reg);
            REG_BASE_Y:      prdata = 32'(base_y_reg);
            REG_START_ANGLE: prdata = 32'(start_reg);
            REG_LINK_LENGTH: prdata = 32'(len_reg);
            REG_JOINT_LIMIT: prdata = 32'(jlim_reg);
            REG_STEP_LIMIT:  prdata = 32'(slim_reg);
            default:         prdata = 32'h0;
        endcase
    end

    // datapath arithmetic shared by several states
    always_comb
    begin
        in_fire  = in_valid && (state_reg == ST_IDLE);
        out_free = !out_valid_reg || out_ready;
        last_j   = (jcnt_reg == JW'(NUM_JOINTS - 1));
        jcnt_inc = (JW+1)'(jcnt_reg) + 1'b1;

        // one joint read port: active joint when it is updated or judged
        rd_idx = ((state_reg == ST_G_ADD) || (state_reg == ST_DONE)) ? act_reg : jcnt_reg;
        ang_rd = ang_mem_reg[rd_idx];
        vel_rd = vel_mem_reg[rd_idx];

        // rotation mode: fold the angle into +-quarter turn
        rot_z    = CZW'(signed'({ang_reg, 16'h0000}));
        rot_flip = (rot_z > Z_QTR) || (rot_z < -Z_QTR);
        if (rot_z > Z_QTR) begin
            rot_z0 = rot_z - Z_HALF;
        end else if (rot_z < -Z_QTR) begin
            rot_z0 = rot_z + Z_HALF;
        end else begin
            rot_z0 = rot_z;
        end

        rc_wide = (cor_x + CXW'(32768)) >>> 16;
        rs_wide = (cor_y + CXW'(32768)) >>> 16;
        rc      = rc_wide[18:0];
        rs      = rs_wide[18:0];
        rc_f    = flip_reg ? -rc : rc;
        rs_f    = flip_reg ? -rs : rs;
        px_new  = sat20(22'(px_reg) + 22'(rc_f));
        py_new  = sat20(22'(py_reg) + 22'(rs_f));

        // vectoring mode: start in the right half plane
        vec_neg  = dot_reg[DW-1];
        vec_zero = (dot_reg == '0) && (cross_reg == '0);
        dot_x    = CXW'(dot_reg);
        cross_x  = CXW'(cross_reg);
        vec_x0   = vec_neg ? -dot_x : dot_x;
        vec_y0   = vec_neg ? -cross_x : cross_x;

        vz_round = (cor_z + CZW'(32768)) >>> 16;
        vang     = vz_round[15:0];
        vang17   = 17'(vang);
        slim17   = signed'({3'b000, slim_reg});
        if (vang17 > slim17) begin
            err17 = slim17;
        end else if (vang17 < -slim17) begin
            err17 = -slim17;
        end else begin
            err17 = vang17;
        end

        // velocity kick from the angle error
        g_round = (prod_reg + MPW'(128)) >>> 8;
        g18     = g_round[17:0];
        vsum    = 26'(vel_rd) + 26'(g18);
        if (vsum > 26'(VEL_MAX)) begin
            vsat = 24'(VEL_MAX);
        end else if (vsum < 26'(VEL_MIN)) begin
            vsat = 24'(VEL_MIN);
        end else begin
            vsat = vsum[23:0];
        end

        // joint integration and clamp
        vr_wide = (25'(vel_rd) + 25'sd128) >>> 8;
        vr      = vr_wide[16:0];
        asum    = 18'(ang_rd) + 18'(vr);
        jl18    = signed'({4'b0000, jlim_reg});
        if (asum > jl18) begin
            aclamp = jl18[15:0];
        end else if (asum < -jl18) begin
            aclamp = 16'(-jl18);
        end else begin
            aclamp = asum[15:0];
        end

        // velocity decay
        d_round = (prod_reg + MPW'(32768)) >>> 16;

        // end of step decision
        jl16     = signed'({2'b00, jlim_reg});
        hit      = (ang_rd == jl16) || (ang_rd == -jl16);
        dist_sat = (root > ROOTW'(DIST_MAX)) ? 20'(DIST_MAX) : root[19:0];
        grew     = dist_reg > last_reg;
        move_on  = grew || hit || (upd_reg > 6'(MAX_UPDATES));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_F_MUL;
            ST_F_MUL:  state_next = ST_F_ROT;
            ST_F_ROT:  state_next = ST_F_WAIT;
            ST_F_WAIT:
                if (cor_done) begin
                    if (!last_j) begin
                        state_next = ST_F_MUL;
                    end else if (post_reg) begin
                        state_next = ST_S_MUL;
                    end else begin
                        state_next = ST_D_MUL;
                    end
                end
            ST_D_MUL:  if (mstep_reg == 3'd4) state_next = ST_D_VEC;
            ST_D_VEC:  state_next = vec_zero ? ST_G_MUL : ST_D_WAIT;
            ST_D_WAIT: if (cor_done) state_next = ST_G_MUL;
            ST_G_MUL:  state_next = ST_G_ADD;
            ST_G_ADD:  state_next = ST_J_ANG;
            ST_J_ANG:  state_next = ST_J_VEL;
            ST_J_VEL:  state_next = last_j ? ST_F_MUL : ST_J_ANG;
            ST_S_MUL:  if (mstep_reg == 3'd2) state_next = ST_S_ROOT;
            ST_S_ROOT: state_next = ST_S_WAIT;
            ST_S_WAIT: if (sq_done) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // unit controls and multiplier operands
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        cor_req.start = (state_reg == ST_F_ROT) || ((state_reg == ST_D_VEC) && !vec_zero);
        cor_req.mode  = (state_reg == ST_D_VEC) ? CORDIC_VECTOR : CORDIC_ROTATE;
        if (state_reg == ST_D_VEC) begin
            cor_x0 = vec_x0;
            cor_y0 = vec_y0;
            cor_z0 = vec_neg ? Z_HALF : '0;
        end else begin
            cor_x0 = prod_reg[CXW-1:0];
            cor_y0 = '0;
            cor_z0 = rot_z0;
        end
        sq_start = (state_reg == ST_S_ROOT);

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_F_MUL:
            begin
                mul_a = MAW'(snap_len_reg);
                mul_b = MBW'(GAIN_Q16);
            end
            ST_D_MUL:
            begin
                case (mstep_reg)
                    3'd0:    begin mul_a = MAW'(tx_reg); mul_b = MBW'(vx_reg); end
                    3'd1:    begin mul_a = MAW'(ty_reg); mul_b = MBW'(vy_reg); end
                    3'd2:    begin mul_a = MAW'(tx_reg); mul_b = MBW'(vy_reg); end
                    3'd3:    begin mul_a = MAW'(ty_reg); mul_b = MBW'(vx_reg); end
                    default: ;
                endcase
            end
            ST_G_MUL:
            begin
                mul_a = MAW'(err_reg);
                mul_b = MBW'(VEL_GAIN_Q16);
            end
            ST_J_ANG:
            begin
                mul_a = MAW'(vel_rd);
                mul_b = MBW'(VEL_DECAY_Q16);
            end
            ST_S_MUL:
            begin
                case (mstep_reg)
                    3'd0:    begin mul_a = MAW'(vx_reg); mul_b = MBW'(vx_reg); end
                    3'd1:    begin mul_a = MAW'(vy_reg); mul_b = MBW'(vy_reg); end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // register updates
    always_comb
    begin
        jcnt_next       = jcnt_reg;
        act_next        = act_reg;
        mstep_next      = mstep_reg;
        post_next       = post_reg;
        upd_next        = upd_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        snap_bx_next    = snap_bx_reg;
        snap_by_next    = snap_by_reg;
        snap_start_next = snap_start_reg;
        snap_len_next   = snap_len_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        jx_next         = jx_reg;
        jy_next         = jy_reg;
        ang_next        = ang_reg;
        flip_next       = flip_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        vx_next         = vx_reg;
        vy_next         = vy_reg;
        dot_next        = dot_reg;
        cross_next      = cross_reg;
        err_next        = err_reg;
        sq_next         = sq_reg;
        dist_next       = dist_reg;
        tip_x_next      = tip_x_reg;
        tip_y_next      = tip_y_reg;
        tdist_next      = tdist_reg;
        tact_next       = tact_reg;
        ang_we          = 1'b0;
        ang_wdata       = aclamp;
        vel_we          = 1'b0;
        vel_widx        = jcnt_reg;
        vel_wdata       = d_round[23:0];

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    // first pass replays the geometry of the last step
                    gx_next   = target_x;
                    gy_next   = target_y;
                    px_next   = snap_bx_reg;
                    py_next   = snap_by_reg;
                    jx_next   = snap_bx_reg;
                    jy_next   = snap_by_reg;
                    ang_next  = snap_start_reg;
                    jcnt_next = '0;
                    post_next = 1'b0;
                end
            end
            ST_F_MUL:  ang_next = ang_reg + ang_rd;
            ST_F_ROT:  flip_next = rot_flip;
            ST_F_WAIT:
            begin
                if (cor_done) begin
                    px_next = px_new;
                    py_next = py_new;
                    if (!post_reg && (jcnt_inc == (JW+1)'(act_reg))) begin
                        jx_next = px_new;
                        jy_next = py_new;
                    end
                    mstep_next = '0;
                    if (!last_j) begin
                        jcnt_next = jcnt_reg + 1'b1;
                    end else if (!post_reg) begin
                        tx_next = 21'(px_new) - 21'(jx_reg);
                        ty_next = 21'(py_new) - 21'(jy_reg);
                        vx_next = 21'(gx_reg) - 21'(jx_reg);
                        vy_next = 21'(gy_reg) - 21'(jy_reg);
                    end else begin
                        vx_next = 21'(gx_reg) - 21'(px_new);
                        vy_next = 21'(gy_reg) - 21'(py_new);
                    end
                end
            end
            ST_D_MUL:
            begin
                mstep_next = mstep_reg + 1'b1;
                case (mstep_reg)
                    3'd1:    dot_next   = DW'(prod_reg);
                    3'd2:    dot_next   = dot_reg + DW'(prod_reg);
                    3'd3:    cross_next = DW'(prod_reg);
                    3'd4:    cross_next = cross_reg - DW'(prod_reg);
                    default: ;
                endcase
            end
            ST_D_VEC:  if (vec_zero) err_next = '0;
            ST_D_WAIT: if (cor_done) err_next = err17[15:0];
            ST_G_ADD:
            begin
                vel_we    = 1'b1;
                vel_widx  = act_reg;
                vel_wdata = vsat;
                jcnt_next = '0;
            end
            ST_J_ANG:  ang_we = 1'b1;
            ST_J_VEL:
            begin
                vel_we = 1'b1;
                if (last_j) begin
                    // second pass with the current geometry
                    snap_bx_next    = base_x_reg;
                    snap_by_next    = base_y_reg;
                    snap_start_next = start_reg;
                    snap_len_next   = len_reg;
                    px_next         = base_x_reg;
                    py_next         = base_y_reg;
                    ang_next        = start_reg;
                    jcnt_next       = '0;
                    post_next       = 1'b1;
                end else begin
                    jcnt_next = jcnt_reg + 1'b1;
                end
            end
            ST_S_MUL:
            begin
                mstep_next = mstep_reg + 1'b1;
                case (mstep_reg)
                    3'd1:    sq_next = prod_reg[SQW-1:0];
                    3'd2:    sq_next = sq_reg + prod_reg[SQW-1:0];
                    default: ;
                endcase
            end
            ST_S_WAIT: if (sq_done) dist_next = dist_sat;
            ST_DONE:
            begin
                if (out_free) begin
                    if (move_on) begin
                        act_next = (act_reg == '0) ? JW'(NUM_JOINTS - 1) : act_reg - 1'b1;
                        upd_next = '0;
                    end else begin
                        upd_next = upd_reg + 1'b1;
                    end
                    // tip still held from the end of the second pass
                    tip_x_next     = px_reg;
                    tip_y_next     = py_reg;
                    last_next      = dist_reg;
                    tdist_next     = dist_reg;
                    tact_next      = 4'(move_on ? ((act_reg == '0) ? JW'(NUM_JOINTS - 1)
                                                   : act_reg - 1'b1) : act_reg);
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            jcnt_reg       <= '0;
            act_reg        <= JW'(NUM_JOINTS - 1);
            mstep_reg      <= '0;
            post_reg       <= 1'b0;
            upd_reg        <= '0;
            last_reg       <= 20'(DIST_MAX);
            out_valid_reg  <= 1'b0;
            snap_bx_reg    <= BASE_X_RST;
            snap_by_reg    <= BASE_Y_RST;
            snap_start_reg <= START_ANGLE_RST;
            snap_len_reg   <= LINK_LENGTH_RST;
            for (int i = 0; i < NUM_JOINTS; i++) begin
                ang_mem_reg[i] <= '0;
                vel_mem_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            jcnt_reg       <= jcnt_next;
            act_reg        <= act_next;
            mstep_reg      <= mstep_next;
            post_reg       <= post_next;
            upd_reg        <= upd_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
            snap_bx_reg    <= snap_bx_next;
            snap_by_reg    <= snap_by_next;
            snap_start_reg <= snap_start_next;
            snap_len_reg   <= snap_len_next;
            if (ang_we) begin
                ang_mem_reg[jcnt_reg] <= ang_wdata;
            end
            if (vel_we) begin
                vel_mem_reg[vel_widx] <= vel_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        gx_reg    <= gx_next;
        gy_reg    <= gy_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        jx_reg    <= jx_next;
        jy_reg    <= jy_next;
        ang_reg   <= ang_next;
        flip_reg  <= flip_next;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        dot_reg   <= dot_next;
        cross_reg <= cross_next;
        err_reg   <= err_next;
        sq_reg    <= sq_next;
        dist_reg  <= dist_next;
        tip_x_reg <= tip_x_next;
        tip_y_reg <= tip_y_next;
        tdist_reg <= tdist_next;
        tact_reg  <= tact_next;
    end

    ikcd_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (cor_req),
        .x_init (cor_x0),
        .y_init (cor_y0),
        .z_init (cor_z0),
        .done   (cor_done),
        .x_out  (cor_x),
        .y_out  (cor_y),
        .z_out  (cor_z)
    );

    ikcd_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_reg),
        .done  (sq_done),
        .root  (root)
    );

    assign out_valid    = out_valid_reg;
    assign tip_x        = tip_x_reg;
    assign tip_y        = tip_y_reg;
    assign tip_distance = tdist_reg;
    assign active_joint = tact_reg;

endmodule

### design/ikcd_cordic.sv
// iterative cordic, one micro-rotation per cycle, rotation and vectoring modes
`timescale 1ns / 1ps
module ikcd_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ikcd_pkg::cordic_req_t               req,
    input  logic signed [ikcd_pkg::CXW-1:0]     x_init,
    input  logic signed [ikcd_pkg::CXW-1:0]     y_init,
    input  logic signed [ikcd_pkg::CZW-1:0]     z_init,
    output logic                                done,
    output logic signed [ikcd_pkg::CXW-1:0]     x_out,
    output logic signed [ikcd_pkg::CXW-1:0]     y_out,
    output logic signed [ikcd_pkg::CZW-1:0]     z_out
);
    import ikcd_pkg::*;

    logic signed [CXW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [CZW-1:0] z_reg, z_next;
    logic [CIW-1:0]        it_reg, it_next;
    logic                  busy_reg, busy_next, done_reg, done_next;
    cordic_mode_t          mode_reg, mode_next;

    logic signed [CXW-1:0] dx, dy;
    logic signed [CZW-1:0] dz;
    logic                  sigma;

    always_comb
    begin
        dx = y_reg >>> it_reg;
        dy = x_reg >>> it_reg;
        dz = signed'({{(CZW-32){1'b0}}, atan_entry(5'(it_reg))});
        // sigma set: x -= dx, y += dy, z -= dz
        if (mode_reg == CORDIC_ROTATE) begin
            sigma = !z_reg[CZW-1];
        end else begin
            sigma = y_reg[CXW-1] || (y_reg == '0);
        end

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        mode_next = mode_reg;
        done_next = 1'b0;

        if (req.start) begin
            x_next    = x_init;
            y_next    = y_init;
            z_next    = z_init;
            mode_next = req.mode;
            it_next   = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sigma) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - dz;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + dz;
            end
            if (it_reg == CIW'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                it_next = it_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
            mode_reg <= CORDIC_ROTATE;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

### design/ikcd_isqrt.sv
// bit-serial integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
module ikcd_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ikcd_pkg::SQW-1:0]      value,
    output logic                          done,
    output logic [ikcd_pkg::ROOTW-1:0]    root
);
    import ikcd_pkg::*;

    logic [SQW:0]   v_reg, v_next, r_reg, r_next, bit_reg, bit_next;
    logic [RCW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next, done_reg, done_next;
    logic [SQW:0]   trial;

    always_comb
    begin
        trial     = r_reg + bit_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            v_next    = (SQW+1)'(value);
            r_next    = '0;
            bit_next  = (SQW+1)'(1) << (2 * (ROOTW - 1));
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (cnt_reg == RCW'(ROOTW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg[ROOTW-1:0];

endmodule

### tb/tb_ccd_inverse_kinematics_step.sv
// testbench for the ccd inverse kinematics step: bit-true predictor, scoreboard and drivers
`timescale 1ns / 1ps
module tb_ccd_inverse_kinematics_step;
    import ikcd_pkg::*;

    localparam int NJ          = ikcd_pkg::NUM_JOINTS;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int HOLD_CYCLES  = 4000;

    // expected tip result of one step
    typedef struct {
        logic [19:0] tip_x;
        logic [19:0] tip_y;
        logic [19:0] tdist;
        logic [3:0]  joint;
    } tip_result_t;

    // chain model plus the queue of tip results still owed by the block
    class ik_scoreboard;
        longint bx, by, sa, ll, jl, sl;
        longint ang[NJ];
        longint vel[NJ];
        longint px[NJ+1];
        longint py[NJ+1];
        longint last_dist;
        int     act, upd;
        longint atan_q32[24];
        tip_result_t owed[$];
        int     mismatches;

        function new();
            atan_q32 = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                         64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                         64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                         64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                         64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                         64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
            mismatches = 0;
            bx = 102400; by = 102400; sa = 49152; ll = 4096; jl = 1043; sl = 1043;
            for (int i = 0; i < NJ; i++) begin
                ang[i] = 0;
                vel[i] = 0;
            end
            last_dist = DIST_MAX;
            act = NJ - 1;
            upd = 0;
            rebuild_chain();
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // len * (cos, sin) of a 16-bit angle
        function void polar(longint len, longint a16, output longint c, output longint s);
            longint z, x, y, dx, dy;
            bit flip;
            z = (a16 & 64'hFFFF) <<< 16;
            flip = 0;
            if (z >= 64'sh80000000) z -= 64'sh100000000;
            if (z > 64'sh40000000) begin
                z -= 64'sh80000000;
                flip = 1;
            end else if (z < -64'sh40000000) begin
                z += 64'sh80000000;
                flip = 1;
            end
            x = len * GAIN_Q16;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_q32[i];
                end else begin
                    x += dx; y -= dy; z += atan_q32[i];
                end
            end
            c = round_shift(x, 16);
            s = round_shift(y, 16);
            if (flip) begin
                c = -c;
                s = -s;
            end
        endfunction

        // atan2 in signed 16-bit angle units
        function longint heading(longint ax, longint ay);
            longint x, y, z, dx, dy, r;
            if (ax == 0 && ay == 0) return 0;
            x = ax; y = ay; z = 0;
            if (x < 0) begin
                x = -x; y = -y; z = 64'sh80000000;
            end
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; z += atan_q32[i];
                end else begin
                    x -= dx; y += dy; z -= atan_q32[i];
                end
            end
            r = round_shift(z, 16);
            if (r >= 32768) r -= 65536;
            if (r < -32768) r += 65536;
            return r;
        endfunction

        function void rebuild_chain();
            longint x, y, c, s, a;
            x = bx; y = by; a = sa;
            px[0] = x; py[0] = y;
            for (int i = 0; i < NJ; i++) begin
                a = (a + ang[i]) & 64'hFFFF;
                polar(ll, a, c, s);
                x = clip(x + c, -524288, 524287);
                y = clip(y + s, -524288, 524287);
                px[i+1] = x; py[i+1] = y;
            end
        endfunction

        function longint int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function void set_reg(reg_index_t idx, logic [31:0] val);
            case (idx)
                REG_BASE_X:      bx = longint'($signed(val[19:0]));
                REG_BASE_Y:      by = longint'($signed(val[19:0]));
                REG_START_ANGLE: sa = longint'(val[15:0]);
                REG_LINK_LENGTH: ll = longint'(val[15:0]);
                REG_JOINT_LIMIT: jl = longint'(val[13:0]);
                REG_STEP_LIMIT:  sl = longint'(val[13:0]);
                default: ;
            endcase
        endfunction

        // one step of the solver for an accepted target
        function void note_target(logic signed [19:0] gx_in, logic signed [19:0] gy_in);
            longint gx, gy, jx, jy, tx, ty, vx, vy, dotp, crossp, err, v, dx, dy, dnow;
            int a;
            bit hit, grew;
            tip_result_t r;
            gx = gx_in; gy = gy_in;
            a = act;
            jx = px[a]; jy = py[a];
            tx = px[NJ] - jx; ty = py[NJ] - jy;
            vx = gx - jx; vy = gy - jy;
            dotp = tx * vx + ty * vy;
            crossp = tx * vy - ty * vx;
            err = clip(heading(dotp, crossp), -sl, sl);
            v = vel[a] + round_shift(err * VEL_GAIN_Q16, 8);
            vel[a] = clip(v, VEL_MIN, VEL_MAX);
            for (int i = 0; i < NJ; i++) begin
                v = ang[i] + round_shift(vel[i], 8);
                ang[i] = clip(v, -jl, jl);
                vel[i] = round_shift(vel[i] * VEL_DECAY_Q16, 16);
            end
            rebuild_chain();
            hit = (ang[a] == jl) || (ang[a] == -jl);
            dx = gx - px[NJ];
            dy = gy - py[NJ];
            dnow = int_sqrt(longint'(dx * dx + dy * dy));
            if (dnow > DIST_MAX) dnow = DIST_MAX;
            grew = dnow > last_dist;
            if (grew || hit || upd > MAX_UPDATES) begin
                act = (a < 1) ? NJ - 1 : a - 1;
                upd = 0;
            end else begin
                upd++;
            end
            last_dist = dnow;
            r.tip_x = px[NJ][19:0];
            r.tip_y = py[NJ][19:0];
            r.tdist = dnow[19:0];
            r.joint = act[3:0];
            owed = {owed, r};
        endfunction

        function void check_tip(logic [19:0] tx, logic [19:0] ty, logic [19:0] d,
                                logic [3:0] j);
            tip_result_t e;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: tip %h %h dist %h joint %h", tx, ty, d, j);
                return;
            end
            e = owed.pop_front();
            if (e.tip_x !== tx || e.tip_y !== ty || e.tdist !== d || e.joint !== j) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp tip %h %h dist %h joint %h, got %h %h %h %h",
                             e.tip_x, e.tip_y, e.tdist, e.joint, tx, ty, d, j);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [19:0] target_x = '0, target_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [19:0] tip_x, tip_y;
    logic [19:0]        tip_distance;
    logic [3:0]         active_joint;

    ik_scoreboard sb = new();
    int  results_seen = 0;
    longint cycles = 0;

    ccd_inverse_kinematics_step dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .target_x(target_x), .target_y(target_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .tip_x(tip_x), .tip_y(tip_y), .tip_distance(tip_distance),
        .active_joint(active_joint)
    );

    always #5 clk = ~clk;

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // apb write: setup cycle, access cycle, register taken at the access edge
    task automatic reg_write(reg_index_t idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_geometry(logic [19:0] bxv, logic [19:0] byv, logic [15:0] sav,
                                logic [15:0] llv, logic [13:0] jlv, logic [13:0] slv);
        reg_write(REG_BASE_X, {12'd0, bxv});
        reg_write(REG_BASE_Y, {12'd0, byv});
        reg_write(REG_START_ANGLE, {16'd0, sav});
        reg_write(REG_LINK_LENGTH, {16'd0, llv});
        reg_write(REG_JOINT_LIMIT, {18'd0, jlv});
        reg_write(REG_STEP_LIMIT, {18'd0, slv});
    endtask

    // offer one target after a random gap; valid stays up across back-to-back transfers
    task automatic send_target(logic signed [19:0] gx, logic signed [19:0] gy);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        target_x <= gx;
        target_y <= gy;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_target(gx, gy);
    endtask

    // every target sent so far has its result back; block is idle again
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic signed [19:0] sat_coord(longint v);
        return v > 524287 ? 20'sd524287 : (v < -524288 ? -20'sd524288 : 20'(v));
    endfunction

    // mostly targets within reach of the chain, some anywhere in the field
    task automatic random_targets(int n);
        longint reach;
        logic signed [19:0] gx, gy;
        for (int k = 0; k < n; k++) begin
            reach = sb.ll * NJ + 256;
            if ($urandom_range(0, 4) == 0) begin
                gx = 20'($urandom);
                gy = 20'($urandom);
            end else begin
                gx = sat_coord(sb.bx + longint'($urandom_range(0, 2 * reach)) - reach);
                gy = sat_coord(sb.by + longint'($urandom_range(0, 2 * reach)) - reach);
            end
            send_target(gx, gy);
        end
    endtask

    // result side: random ready gaps plus one long hold-off so the block backs up
    initial
    begin
        int gap;
        bit held;
        held = 0;
        @(posedge rst_n);
        forever begin
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (!held && results_seen == 300) begin
                gap = HOLD_CYCLES;
                held = 1;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_tip(tip_x, tip_y, tip_distance, active_joint);
            results_seen++;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: tip on target, target on the active joint, on the base,
        // opposite the tip, and the corners of the field
        send_target(20'sd102400, 20'sd36864);
        send_target(20'sd102400, 20'sd36864);
        send_target(sat_coord(sb.px[sb.act]), sat_coord(sb.py[sb.act]));
        send_target(20'sd102400, 20'sd102400);
        send_target(20'sd102400, 20'sd524287);
        send_target(-20'sd524288, -20'sd524288);
        send_target(20'sd524287, 20'sd524287);
        send_target(-20'sd524288, 20'sd524287);
        send_target(20'sd524287, -20'sd524288);
        send_target(20'sd0, 20'sd0);
        send_target(-20'sd1, 20'sd1);
        for (int k = 0; k < 9; k++)
            send_target(sat_coord(sb.px[sb.act]), sat_coord(sb.py[sb.act]));
        drain();

        // wide limits, base at origin
        set_geometry(20'd0, 20'd0, 16'd0, 16'd4096, 14'd16383, 14'd16383);
        random_targets(150);
        drain();

        // zero joint limit: joints frozen, active joint walks every step
        set_geometry(20'd102400, 20'd102400, 16'd49152, 16'd4096, 14'd0, 14'd1043);
        random_targets(100);
        drain();

        // field corners, longest links, no steering
        set_geometry(20'h80000, 20'h7FFFF, 16'hFFFF, 16'hFFFF, 14'd1043, 14'd0);
        random_targets(80);
        drain();

        // zero length links: whole chain collapses onto the base
        set_geometry(20'h7FFFF, 20'h80000, 16'd16384, 16'd0, 14'd8000, 14'd16383);
        send_target(-20'sd524288, 20'sd524287);
        random_targets(50);
        drain();

        // random settings with mostly short links
        for (int p = 0; p < 5; p++) begin
            set_geometry(20'($urandom_range(0, 65535) - 32768),
                         20'($urandom_range(0, 65535) - 32768),
                         16'($urandom), 16'($urandom_range(64, 8192)),
                         14'($urandom), 14'($urandom));
            random_targets(145);
            drain();
        end

        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
